[hw/rtl/hpe_pkg.sv]
// Package for the holographic pixel effect: stage structs, constants and
// the noise curve function. No dependencies.
package hpe_pkg;

  localparam int unsigned NoiseDiv  = 40000;
  localparam logic [6:0]  BandMask  = 7'h7f;
  localparam logic [6:0]  BandLimit = 7'h58;
  localparam logic [6:0]  PhaseStep = 7'd37;
  localparam logic signed [11:0] LumaBias    = 12'sd100;
  localparam logic signed [11:0] FloorBright = 12'sd20;
  localparam logic signed [11:0] FloorDark   = 12'sd0;
  localparam logic [11:0] OffsDark = 12'd10;
  localparam logic [11:0] OffsBlue = 12'd40;
  localparam logic [11:0] SatMax   = 12'd255;

  typedef struct packed {
    logic        valid;
    logic        moving;
    logic        bright;
    logic [7:0]  sr;
    logic [7:0]  sg;
    logic [7:0]  sb;
    logic [15:0] bg_red;
    logic [15:0] bg_green;
    logic [15:0] bg_blue;
    logic [8:0]  noise;
  } hpe_s1_t;

  typedef struct packed {
    logic        valid;
    logic        moving;
    logic        bright;
    logic [10:0] r_fl;
    logic [10:0] g_fl;
    logic [10:0] b_fl;
    logic [15:0] bg_red;
    logic [15:0] bg_green;
    logic [15:0] bg_blue;
  } hpe_s2_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } hpe_res_t;

  // noise curve: ((i^3 / 40000) * i / 256), 9 bits
  function automatic logic [8:0] noise_entry(input int unsigned i);
    int unsigned c;
    c = ((i * i * i) / NoiseDiv) * i / 256;
    return c[8:0];
  endfunction

endpackage

[hw/rtl/hpe_in_if.sv]
// Pixel input channel: valid/ready handshake with source, background and
// control payload. Depends on nothing.
interface hpe_in_if #(
  parameter int ROW_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [15:0]         src_red;
  logic [15:0]         src_green;
  logic [15:0]         src_blue;
  logic [15:0]         bg_red;
  logic [15:0]         bg_green;
  logic [15:0]         bg_blue;
  logic                moving;
  logic [ROW_BITS-1:0] row;
  logic [7:0]          noise_byte;
  logic                frame_end;

  modport source (
    output valid, src_red, src_green, src_blue, bg_red, bg_green, bg_blue,
           moving, row, noise_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, bg_red, bg_green, bg_blue,
           moving, row, noise_byte, frame_end,
    output ready
  );
endinterface

[hw/rtl/hpe_out_if.sv]
// Pixel result channel: valid/ready handshake with the 16-bit RGB result.
// Depends on nothing.
interface hpe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

[hw/rtl/hpe_front.sv]
// Stage 1: band select from row and phase, noise ROM lookup, input register.
// Holds the band phase. Uses hpe_pkg and hpe_in_if.
module hpe_front #(
  parameter int ROW_BITS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  hpe_in_if.sink          in_ch,
  output hpe_pkg::hpe_s1_t s1_r
);
  import hpe_pkg::*;

  logic [8:0]          noise_rom [256];
  logic [ROW_BITS+6:0] row_ext;
  logic [6:0]          band_pos;
  logic [6:0]          phase_r;
  logic [6:0]          phase_nxt;
  logic                take;
  hpe_s1_t             s1_nxt;

  for (genvar i = 0; i < 256; i++) begin : g_rom
    assign noise_rom[i] = noise_entry(i);
  end

  assign take     = in_ch.valid && en;
  assign row_ext  = {7'b0, in_ch.row};
  assign band_pos = (row_ext[6:0] + phase_r) & BandMask;

  always_comb begin
    phase_nxt = phase_r;
    if (take && in_ch.frame_end) begin
      phase_nxt = phase_r - PhaseStep;
    end
  end

  always_comb begin
    s1_nxt.valid    = in_ch.valid;
    s1_nxt.moving   = in_ch.moving;
    s1_nxt.bright   = band_pos < BandLimit;
    s1_nxt.sr       = in_ch.src_red[15:8];
    s1_nxt.sg       = in_ch.src_green[15:8];
    s1_nxt.sb       = in_ch.src_blue[15:8];
    s1_nxt.bg_red   = in_ch.bg_red;
    s1_nxt.bg_green = in_ch.bg_green;
    s1_nxt.bg_blue  = in_ch.bg_blue;
    s1_nxt.noise    = noise_rom[in_ch.noise_byte];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      s1_r.valid <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (en) begin
        s1_r.valid <= s1_nxt.valid;
      end
    end
    if (en) begin
      s1_r.moving   <= s1_nxt.moving;
      s1_r.bright   <= s1_nxt.bright;
      s1_r.sr       <= s1_nxt.sr;
      s1_r.sg       <= s1_nxt.sg;
      s1_r.sb       <= s1_nxt.sb;
      s1_r.bg_red   <= s1_nxt.bg_red;
      s1_r.bg_green <= s1_nxt.bg_green;
      s1_r.bg_blue  <= s1_nxt.bg_blue;
      s1_r.noise    <= s1_nxt.noise;
    end
  end
endmodule

[hw/rtl/hpe_mix.sv]
// Stage 2: luma-like sum with noise, per-channel scale, bias and floor
// for red and green. Uses hpe_pkg.
module hpe_mix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  hpe_pkg::hpe_s1_t s1,
  output hpe_pkg::hpe_s2_t s2_r
);
  import hpe_pkg::*;

  logic [10:0]        g_mul;
  logic [10:0]        t;
  logic [7:0]         r_add;
  logic [11:0]        r_sum, g_sum, b_sum;
  logic signed [11:0] r_pre, g_pre, lim;
  logic signed [11:0] r_cl, g_cl;
  hpe_s2_t            s2_nxt;

  always_comb begin
    g_mul = s1.bright ? {2'b0, s1.sg, 1'b0} : {1'b0, s1.sg, 2'b0};
    t     = 11'(s1.sr) + 11'(s1.sb) + g_mul + 11'(s1.noise);
    r_add = s1.bright ? {1'b0, s1.sr[7:1]} : s1.sr;
    r_sum = 12'(t) + 12'(r_add);
    g_sum = 12'(t) + 12'(s1.sg);
    b_sum = 12'(t) + 12'(s1.sb);
    r_pre = $signed({1'b0, r_sum[11:1]}) - LumaBias;
    g_pre = $signed({1'b0, g_sum[11:1]}) - LumaBias;
    lim   = s1.bright ? FloorBright : FloorDark;
    r_cl  = (r_pre < lim) ? lim : r_pre;
    g_cl  = (g_pre < lim) ? lim : g_pre;

    s2_nxt.valid    = s1.valid;
    s2_nxt.moving   = s1.moving;
    s2_nxt.bright   = s1.bright;
    s2_nxt.r_fl     = r_cl[10:0];
    s2_nxt.g_fl     = g_cl[10:0];
    s2_nxt.b_fl     = {1'b0, b_sum[11:2]};
    s2_nxt.bg_red   = s1.bg_red;
    s2_nxt.bg_green = s1.bg_green;
    s2_nxt.bg_blue  = s1.bg_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r.valid <= s2_nxt.valid;
    end
    if (en) begin
      s2_r.moving   <= s2_nxt.moving;
      s2_r.bright   <= s2_nxt.bright;
      s2_r.r_fl     <= s2_nxt.r_fl;
      s2_r.g_fl     <= s2_nxt.g_fl;
      s2_r.b_fl     <= s2_nxt.b_fl;
      s2_r.bg_red   <= s2_nxt.bg_red;
      s2_r.bg_green <= s2_nxt.bg_green;
      s2_r.bg_blue  <= s2_nxt.bg_blue;
    end
  end
endmodule

[hw/rtl/hpe_blend.sv]
// Stage 3: background blend, offset, saturation, byte replication and the
// output register. Uses hpe_pkg.
module hpe_blend (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  hpe_pkg::hpe_s2_t s2,
  output hpe_pkg::hpe_res_t res_r
);
  import hpe_pkg::*;

  logic [11:0] r_sum, g_sum, b_sum, offs;
  logic [7:0]  r8, g8, b8;
  hpe_res_t    res_nxt;

  always_comb begin
    offs  = s2.bright ? 12'd0 : OffsDark;
    r_sum = 12'(s2.r_fl) + 12'(s2.bg_red[15:9]) + offs;
    g_sum = 12'(s2.g_fl) + 12'(s2.bg_green[15:9]) + offs;
    b_sum = 12'(s2.b_fl) + 12'(s2.bg_blue[15:9]) + OffsBlue;
    r8    = (r_sum > SatMax) ? SatMax[7:0] : r_sum[7:0];
    g8    = (g_sum > SatMax) ? SatMax[7:0] : g_sum[7:0];
    b8    = (b_sum > SatMax) ? SatMax[7:0] : b_sum[7:0];

    res_nxt.valid = s2.valid;
    res_nxt.red   = s2.moving ? {r8, r8} : s2.bg_red;
    res_nxt.green = s2.moving ? {g8, g8} : s2.bg_green;
    res_nxt.blue  = s2.moving ? {b8, b8} : s2.bg_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (en) begin
      res_r.valid <= res_nxt.valid;
    end
    if (en) begin
      res_r.red   <= res_nxt.red;
      res_r.green <= res_nxt.green;
      res_r.blue  <= res_nxt.blue;
    end
  end
endmodule

[hw/rtl/holographic_pixel_effect_top.sv]
// Holographic pixel effect, top level: three-stage pixel pipeline.
// Uses hpe_pkg, hpe_in_if, hpe_out_if, hpe_front, hpe_mix, hpe_blend.
//
// Usage:
//   in_ch  - one pixel per transfer: source and background RGB (16 bit),
//            moving flag, row, noise index and frame-end flag.
//   out_ch - one RGB result per input pixel, in input order.
//   Moving pixels get the banded hologram tint; still pixels pass the
//   background through. A frame-end pixel steps the band phase down by 37
//   for the pixels that follow it.
//   Pipeline: three register stages, s1 (hpe_front), s2 (hpe_mix) and
//   res (hpe_blend); res drives out_ch directly.
//   Throughput: one pixel per cycle when not stalled; stages move together.
//   Stall: when a result waits and out_ch.ready is low, the whole pipe
//   holds, bubbles included, and in_ch.ready drops; nothing is lost or
//   repeated.
//   Reset: band phase returns to 0, all stage valids clear and in_ch.ready
//   stays low; the noise curve is a constant table and needs no set-up.
module holographic_pixel_effect_top #(
  parameter int ROW_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  hpe_in_if.sink     in_ch,
  hpe_out_if.source  out_ch
);
  import hpe_pkg::*;

  logic     en;
  hpe_s1_t  s1;
  hpe_s2_t  s2;
  hpe_res_t res;

  assign en          = !res.valid || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  hpe_front #(.ROW_BITS(ROW_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_ch (in_ch),
    .s1_r  (s1)
  );

  hpe_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .s1    (s1),
    .s2_r  (s2)
  );

  hpe_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .s2    (s2),
    .res_r (res)
  );

  assign out_ch.valid     = res.valid;
  assign out_ch.out_red   = res.red;
  assign out_ch.out_green = res.green;
  assign out_ch.out_blue  = res.blue;

  a_stall_holds_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(s2))
    else $error("stage 2 moved during output stall");

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input refused with empty output");

  a_mid_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2.valid && en) |=> out_ch.valid)
    else $error("stage 2 item lost on the way out");
endmodule

[tb/sv/holographic_pixel_effect_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for holographic_pixel_effect_top: directed and random
// pixel transfers with random idling on both sides, predicted in the bench.
// Depends on hpe_in_if, hpe_out_if and the block under test.
module holographic_pixel_effect_top_test;

  localparam int ROW_BITS = 12;
  localparam int N_RANDOM = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [6:0] BAND_EDGE = 7'h58;
  localparam logic [6:0] PHASE_DROP = 7'd37;

  typedef struct {
    logic [15:0]         src_red;
    logic [15:0]         src_green;
    logic [15:0]         src_blue;
    logic [15:0]         bg_red;
    logic [15:0]         bg_green;
    logic [15:0]         bg_blue;
    logic                moving;
    logic [ROW_BITS-1:0] row;
    logic [7:0]          noise_byte;
    logic                frame_end;
    int                  gap;
    bit                  drain;
  } pixel_item_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hpe_in_if #(.ROW_BITS(ROW_BITS)) in_ch();
  hpe_out_if out_ch();

  holographic_pixel_effect_top #(.ROW_BITS(ROW_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pixel_item_t pixel_queue[$];
  rgb_t        expected_rgb[$];
  int unsigned noise_lut[256];
  logic [6:0]  band_ph = 7'd0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  pixel_item_t nxt_px;
  int          out_hold = 0;
  int          n_err = 0;
  int          n_out = 0;
  int          n_moving = 0;
  int          n_bright = 0;
  int          n_frame = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] clip8(input int v);
    if (v > 255) return 8'd255;
    if (v < 0) return 8'd0;
    return v[7:0];
  endfunction

  function automatic rgb_t hologram(input pixel_item_t p, input logic [6:0] ph);
    int r8, g8, b8, t, r, g, b;
    logic [6:0] band;
    rgb_t res;
    r8 = p.src_red[15:8];
    g8 = p.src_green[15:8];
    b8 = p.src_blue[15:8];
    band = p.row[6:0] + ph;
    if (!p.moving) begin
      res.red = p.bg_red;
      res.green = p.bg_green;
      res.blue = p.bg_blue;
      return res;
    end
    if (band < BAND_EDGE) begin
      t = r8 + 2 * g8 + b8 + noise_lut[p.noise_byte];
      r = (((r8 >> 1) + t) >> 1) - 100;
      g = ((g8 + t) >> 1) - 100;
      if (r < 20) r = 20;
      if (g < 20) g = 20;
      r += p.bg_red[15:9];
      g += p.bg_green[15:9];
    end else begin
      t = r8 + 4 * g8 + b8 + noise_lut[p.noise_byte];
      r = ((r8 + t) >> 1) - 100;
      g = ((g8 + t) >> 1) - 100;
      if (r < 0) r = 0;
      if (g < 0) g = 0;
      r += p.bg_red[15:9] + 10;
      g += p.bg_green[15:9] + 10;
    end
    b = ((b8 + t) >> 2) + p.bg_blue[15:9] + 40;
    res.red = {2{clip8(r)}};
    res.green = {2{clip8(g)}};
    res.blue = {2{clip8(b)}};
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_err++;
    end
  endtask

  task automatic add_px(input logic [15:0] sr, sg, sb, br, bgc, bb,
                        input logic mv, input logic [ROW_BITS-1:0] row,
                        input logic [7:0] nb, input logic fe, input int gap);
    pixel_item_t p;
    p.src_red = sr;
    p.src_green = sg;
    p.src_blue = sb;
    p.bg_red = br;
    p.bg_green = bgc;
    p.bg_blue = bb;
    p.moving = mv;
    p.row = row;
    p.noise_byte = nb;
    p.frame_end = fe;
    p.gap = gap;
    p.drain = 1'b0;
    pixel_queue.push_back(p);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // predictor and checker, sampled at the rising edge
  always @(posedge clk) begin
    rgb_t got;
    rgb_t exp_px;
    pixel_item_t acc;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      acc.src_red = in_ch.src_red;
      acc.src_green = in_ch.src_green;
      acc.src_blue = in_ch.src_blue;
      acc.bg_red = in_ch.bg_red;
      acc.bg_green = in_ch.bg_green;
      acc.bg_blue = in_ch.bg_blue;
      acc.moving = in_ch.moving;
      acc.row = in_ch.row;
      acc.noise_byte = in_ch.noise_byte;
      acc.frame_end = in_ch.frame_end;
      expected_rgb.push_back(hologram(acc, band_ph));
      if (acc.moving) begin
        n_moving++;
        if (7'(acc.row[6:0] + band_ph) < BAND_EDGE) n_bright++;
      end
      if (acc.frame_end) begin
        band_ph <= band_ph - PHASE_DROP;
        n_frame++;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.red = out_ch.out_red;
      got.green = out_ch.out_green;
      got.blue = out_ch.out_blue;
      n_out++;
      if (expected_rgb.size() == 0) begin
        $error("unexpected result transfer: %h %h %h", got.red, got.green, got.blue);
        n_err++;
      end else begin
        exp_px = expected_rgb.pop_front();
        check_field("out_red", exp_px.red, got.red);
        check_field("out_green", exp_px.green, got.green);
        check_field("out_blue", exp_px.blue, got.blue);
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pixel_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pixel_queue[0].gap > 0) begin
        pixel_queue[0].gap--;
        in_ch.valid <= 1'b0;
      end else if (pixel_queue[0].drain && expected_rgb.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        nxt_px = pixel_queue.pop_front();
        in_ch.src_red <= nxt_px.src_red;
        in_ch.src_green <= nxt_px.src_green;
        in_ch.src_blue <= nxt_px.src_blue;
        in_ch.bg_red <= nxt_px.bg_red;
        in_ch.bg_green <= nxt_px.bg_green;
        in_ch.bg_blue <= nxt_px.bg_blue;
        in_ch.moving <= nxt_px.moving;
        in_ch.row <= nxt_px.row;
        in_ch.noise_byte <= nxt_px.noise_byte;
        in_ch.frame_end <= nxt_px.frame_end;
        in_ch.valid <= 1'b1;
      end
    end
  end

  // result sink stalls; stretches without stalls every few hundred results
  always @(negedge clk) begin
    if (out_taken) out_hold = ((n_out % 300) < 80) ? 0 : $urandom_range(0, 16);
    if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("holographic_pixel_effect_top_test NOT OK");
    $finish;
  end

  initial begin
    int gap;
    for (int unsigned i = 0; i < 256; i++) begin
      noise_lut[i] = (((i * i * i) / 40000) * i / 256) & 9'h1ff;
    end
    in_ch.valid = 1'b0;
    in_ch.src_red = '0;
    in_ch.src_green = '0;
    in_ch.src_blue = '0;
    in_ch.bg_red = '0;
    in_ch.bg_green = '0;
    in_ch.bg_blue = '0;
    in_ch.moving = 1'b0;
    in_ch.row = '0;
    in_ch.noise_byte = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready = 1'b0;

    // directed: floors, saturation, band edges, still pixels, phase steps
    add_px(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 8'h00, 0, 0);
    add_px(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 0, 8'hff, 0, 0);
    add_px(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 12'h058, 8'h00, 0, 3);
    add_px(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 12'h07f, 8'hff, 0, 0);
    add_px(16'h80ff, 16'h4000, 16'hc000, 16'h1234, 16'h8000, 16'h00ff, 1, 12'h057, 8'h80, 0, 1);
    add_px(16'h7f00, 16'h3300, 16'h9900, 16'h5500, 16'haa00, 16'hff00, 1, 12'hfff, 8'h01, 0, 0);
    add_px(16'h1234, 16'h5678, 16'h9abc, 16'hffff, 16'hffff, 16'hffff, 0, 12'h000, 8'hff, 0, 0);
    add_px(16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 0, 12'hfff, 8'h00, 0, 2);
    add_px(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 1, 12'h010, 8'h00, 0, 0);
    add_px(16'h6000, 16'h6000, 16'h6000, 16'h4000, 16'h4000, 16'h4000, 1, 12'h033, 8'hc0, 1, 0);
    add_px(16'h6000, 16'h6000, 16'h6000, 16'h4000, 16'h4000, 16'h4000, 1, 12'h000, 8'hc0, 0, 0);
    add_px(16'h6000, 16'h6000, 16'h6000, 16'h4000, 16'h4000, 16'h4000, 1, 12'h03c, 8'hc0, 0, 4);
    add_px(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0, 12'h800, 8'h55, 1, 0);
    add_px(16'h3000, 16'h9000, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 1, 12'h022, 8'h40, 0, 0);
    add_px(16'h3000, 16'h9000, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 1, 12'h021, 8'h40, 0, 0);
    add_px(16'hc000, 16'hc000, 16'hc000, 16'h8000, 16'h8000, 16'h8000, 1, 12'h100, 8'hf0, 1, 0);
    add_px(16'hc000, 16'hc000, 16'hc000, 16'h8000, 16'h8000, 16'h8000, 0, 12'h200, 8'hf0, 1, 0);
    add_px(16'hc000, 16'hc000, 16'hc000, 16'h8000, 16'h8000, 16'h8000, 1, 12'h400, 8'hf0, 1, 0);
    add_px(16'h00ff, 16'h00ff, 16'h00ff, 16'h00ff, 16'h00ff, 16'h00ff, 1, 12'h7ff, 8'h7f, 0, 0);
    add_px(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 1, 12'h0aa, 8'hfe, 0, 1);

    for (int k = 0; k < N_RANDOM; k++) begin
      gap = (((k / 150) % 4) == 1) ? 0 : $urandom_range(0, 16);
      add_px(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
             ($urandom_range(0, 4) != 0), ROW_BITS'($urandom), 8'($urandom),
             ($urandom_range(0, 24) == 0), gap);
      if (k == 600 || k == 1200) pixel_queue[pixel_queue.size() - 1].drain = 1'b1;
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (pixel_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d pixels checked: %0d moving (%0d in the bright band), %0d frame ends",
             n_out, n_moving, n_bright, n_frame);
    if (n_err == 0) begin
      $display("holographic_pixel_effect_top_test OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("holographic_pixel_effect_top_test NOT OK");
    end
    $finish;
  end

endmodule

[holographic_pixel_effect_top.f]
hw/rtl/hpe_pkg.sv
hw/rtl/hpe_in_if.sv
hw/rtl/hpe_out_if.sv
hw/rtl/hpe_front.sv
hw/rtl/hpe_mix.sv
hw/rtl/hpe_blend.sv
hw/rtl/holographic_pixel_effect_top.sv
tb/sv/holographic_pixel_effect_top_test.sv
